[sv/pcl_pkg.sv]
`timescale 1ns / 1ps

package pcl_pkg;

	// field widths
	localparam int LINE_W   = 10;
	localparam int SAMPLE_W = 10;
	localparam int LEN_W    = 9;
	localparam int HSYNC_W  = 10;
	localparam int LEVEL_W  = 2;
	localparam int COL_W    = 10;
	localparam int ROW_W    = 10;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 10;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_HSYNC_LENGTH     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_EQUALISING_LENGTH = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BROAD_LENGTH     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_F1_FIRST_LINE    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_F1_LAST_LINE     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_F2_FIRST_LINE    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_F2_LAST_LINE     = 3'd6;

	// register reset values
	localparam logic [HSYNC_W-1:0] RST_HSYNC_LENGTH      = 10'd66;
	localparam logic [LEN_W-1:0]   RST_EQUALISING_LENGTH = 9'd33;
	localparam logic [LEN_W-1:0]   RST_BROAD_LENGTH      = 9'd382;
	localparam logic [LINE_W-1:0]  RST_F1_FIRST_LINE     = 10'd23;
	localparam logic [LINE_W-1:0]  RST_F1_LAST_LINE      = 10'd262;
	localparam logic [LINE_W-1:0]  RST_F2_FIRST_LINE     = 10'd336;
	localparam logic [LINE_W-1:0]  RST_F2_LAST_LINE      = 10'd575;

	// composite level codes
	localparam logic [LEVEL_W-1:0] LVL_SYNC  = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_BLACK = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_WHITE = 2'd2;

	// field sync shape: three groups of five half-line pulses
	localparam int PULSES_PER_GROUP = 5;
	localparam int FIELD_SYNC_HALVES = 3 * PULSES_PER_GROUP;

	// timing defaults
	localparam int SAMPLES_PER_LINE     = 896;
	localparam int HALF_LINE            = 448;
	localparam int SECOND_FIELD_START   = 280000;
	localparam int PICTURE_FIRST_SAMPLE = 191;
	localparam int SOURCE_WIDTH         = 640;

	typedef struct packed {
		logic [HSYNC_W-1:0] hsync_length;
		logic [LEN_W-1:0]   equalising_length;
		logic [LEN_W-1:0]   broad_length;
		logic [LINE_W-1:0]  f1_first_line;
		logic [LINE_W-1:0]  f1_last_line;
		logic [LINE_W-1:0]  f2_first_line;
		logic [LINE_W-1:0]  f2_last_line;
	} cfg_t;

	// field sync flags for one position
	typedef struct packed {
		logic blank;
		logic pulse;
	} fsync_t;

endpackage

[sv/pcl_cfg_regs.sv]
`timescale 1ns / 1ps

module pcl_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [pcl_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pcl_pkg::CFG_DATA_W-1:0]     cfg_data,
	output pcl_pkg::cfg_t                      cfg
);

	pcl_pkg::cfg_t cfg_q;

	// register file, writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hsync_length      <= pcl_pkg::RST_HSYNC_LENGTH;
			cfg_q.equalising_length <= pcl_pkg::RST_EQUALISING_LENGTH;
			cfg_q.broad_length      <= pcl_pkg::RST_BROAD_LENGTH;
			cfg_q.f1_first_line     <= pcl_pkg::RST_F1_FIRST_LINE;
			cfg_q.f1_last_line      <= pcl_pkg::RST_F1_LAST_LINE;
			cfg_q.f2_first_line     <= pcl_pkg::RST_F2_FIRST_LINE;
			cfg_q.f2_last_line      <= pcl_pkg::RST_F2_LAST_LINE;
		end else if (cfg_write) begin
			unique case (cfg_index)
				pcl_pkg::REG_HSYNC_LENGTH: begin
					cfg_q.hsync_length <= cfg_data[pcl_pkg::HSYNC_W-1:0];
				end
				pcl_pkg::REG_EQUALISING_LENGTH: begin
					cfg_q.equalising_length <= cfg_data[pcl_pkg::LEN_W-1:0];
				end
				pcl_pkg::REG_BROAD_LENGTH: begin
					cfg_q.broad_length <= cfg_data[pcl_pkg::LEN_W-1:0];
				end
				pcl_pkg::REG_F1_FIRST_LINE: begin
					cfg_q.f1_first_line <= cfg_data[pcl_pkg::LINE_W-1:0];
				end
				pcl_pkg::REG_F1_LAST_LINE: begin
					cfg_q.f1_last_line <= cfg_data[pcl_pkg::LINE_W-1:0];
				end
				pcl_pkg::REG_F2_FIRST_LINE: begin
					cfg_q.f2_first_line <= cfg_data[pcl_pkg::LINE_W-1:0];
				end
				pcl_pkg::REG_F2_LAST_LINE: begin
					cfg_q.f2_last_line <= cfg_data[pcl_pkg::LINE_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/pcl_field_sync.sv]
`timescale 1ns / 1ps

module pcl_field_sync #(
	parameter int W         = 20,
	parameter int HALF_LINE = pcl_pkg::HALF_LINE
) (
	input  logic [W-1:0]              offset,
	input  logic                      started,
	input  logic [pcl_pkg::LEN_W-1:0] equalising_length,
	input  logic [pcl_pkg::LEN_W-1:0] broad_length,
	output pcl_pkg::fsync_t           flags
);

	localparam int HALVES = pcl_pkg::FIELD_SYNC_HALVES;
	localparam logic [W:0] SPAN = (W+1)'(HALVES * HALF_LINE);

	logic [W:0]        off_x;
	logic [HALVES-1:0] hit;

	assign off_x = {1'b0, offset};

	// one comparator lane per half-line pulse
	for (genvar p = 0; p < HALVES; p++) begin : g_lane
		localparam logic [W:0] LO = (W+1)'(p * HALF_LINE);
		localparam bit IS_BROAD = (p >= pcl_pkg::PULSES_PER_GROUP) &&
			(p < 2 * pcl_pkg::PULSES_PER_GROUP);
		logic [pcl_pkg::LEN_W-1:0] len;
		logic [W:0]                hi;
		assign len    = IS_BROAD ? broad_length : equalising_length;
		assign hi     = LO + (W+1)'(len);
		assign hit[p] = (off_x >= LO) && (off_x < hi);
	end

	// black over the whole sequence, sync where any pulse covers the position
	assign flags.blank = started && (off_x < SPAN);
	assign flags.pulse = started && (|hit);

endmodule

[sv/pal_composite_level_generator_core.sv]
// PAL composite level generator
//
// Input channel (in_valid / in_stall): one sample position per item,
// line_number, sample_index and the source pixel bit pixel_on for the
// coordinates that this position reports.
// Output channel (out_valid / out_stall): the composite level (sync, black,
// white), in_picture, and the source column and row for the position.
// Configuration: cfg_write, cfg_index, cfg_data write one timing register per
// cycle; write only while no item is in flight.
//
// Four register stages: line multiply, frame position add, field-sync pulse
// lanes, level merge. The accepting edge loads the first stage, and out_valid
// rises when the item reaches the fourth. Unless the output stalls, one item is
// taken per cycle, each stage passing one item on per cycle, so items can follow
// back to back. A stalled output holds its item; earlier stages keep filling
// empty slots, and in_stall rises only when every stage holds an item.
// Reset clears all valid bits and restores the default PAL timing registers.
`timescale 1ns / 1ps

module pal_composite_level_generator_core #(
	parameter int SAMPLES_PER_LINE     = pcl_pkg::SAMPLES_PER_LINE,
	parameter int HALF_LINE            = pcl_pkg::HALF_LINE,
	parameter int SECOND_FIELD_START   = pcl_pkg::SECOND_FIELD_START,
	parameter int PICTURE_FIRST_SAMPLE = pcl_pkg::PICTURE_FIRST_SAMPLE,
	parameter int SOURCE_WIDTH         = pcl_pkg::SOURCE_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [pcl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pcl_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [pcl_pkg::LINE_W-1:0]      line_number,
	input  logic [pcl_pkg::SAMPLE_W-1:0]    sample_index,
	input  logic                            pixel_on,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pcl_pkg::LEVEL_W-1:0]     level,
	output logic                            in_picture,
	output logic [pcl_pkg::COL_W-1:0]       source_column,
	output logic [pcl_pkg::ROW_W-1:0]       source_row
);

	// frame position width covers every position, start and sequence span
	localparam int POS_MAX = ((2 ** pcl_pkg::LINE_W) - 1) * SAMPLES_PER_LINE +
		(2 ** pcl_pkg::SAMPLE_W) - 1;
	localparam int SEQ_MAX = pcl_pkg::FIELD_SYNC_HALVES * HALF_LINE + (2 ** pcl_pkg::LEN_W);
	localparam int WIN_MAX = PICTURE_FIRST_SAMPLE + SOURCE_WIDTH;
	localparam int SPAN_A  = (POS_MAX > SECOND_FIELD_START) ? POS_MAX : SECOND_FIELD_START;
	localparam int SPAN_B  = (SPAN_A > SEQ_MAX) ? SPAN_A : SEQ_MAX;
	localparam int SPAN    = (SPAN_B > WIN_MAX) ? SPAN_B : WIN_MAX;
	localparam int POS_W   = $clog2(SPAN + 1);

	// flags and coordinates that ride alongside the position
	typedef struct packed {
		logic                       s_ok;
		logic                       hsync;
		logic                       in_pic;
		logic                       lit;
		logic [pcl_pkg::COL_W-1:0]  col;
		logic [pcl_pkg::ROW_W-1:0]  row;
	} side_t;

	pcl_pkg::cfg_t cfg;

	pcl_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// pipeline handshake, a stage takes a new item when empty or draining
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !v_s4 || !out_stall;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// stage 1: line base, window and active-line decisions
	logic [POS_W-1:0]              prod_n;
	logic [POS_W-1:0]              samp_x;
	logic [POS_W-1:0]              rel_x;
	logic                          win_n;
	logic                          f1_act, f2_act;
	side_t                         side_n;

	always_comb begin
		samp_x = POS_W'(sample_index);
		rel_x  = samp_x - POS_W'(PICTURE_FIRST_SAMPLE);
		prod_n = POS_W'(line_number) * POS_W'(SAMPLES_PER_LINE);
		win_n  = (samp_x >= POS_W'(PICTURE_FIRST_SAMPLE)) && (rel_x < POS_W'(SOURCE_WIDTH));
		f1_act = (line_number >= cfg.f1_first_line) && (line_number <= cfg.f1_last_line);
		f2_act = (line_number >= cfg.f2_first_line) && (line_number <= cfg.f2_last_line);

		side_n.s_ok   = samp_x < POS_W'(SAMPLES_PER_LINE);
		side_n.hsync  = sample_index < cfg.hsync_length;
		side_n.in_pic = side_n.s_ok && win_n && (f1_act || f2_act);
		side_n.lit    = pixel_on;
		side_n.col    = rel_x[pcl_pkg::COL_W-1:0];
		// field one wins where both ranges match
		side_n.row    = f1_act ? (line_number - cfg.f1_first_line)
		                       : (line_number - cfg.f2_first_line);
	end

	logic [POS_W-1:0]             prod_s1;
	logic [pcl_pkg::SAMPLE_W-1:0] samp_s1;
	side_t                        side_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			prod_s1 <= prod_n;
			samp_s1 <= sample_index;
			side_s1 <= side_n;
		end
	end

	// stage 2: frame position and offset into the second field
	logic [POS_W-1:0] pos_n;
	logic [POS_W:0]   diff2_n;

	assign pos_n   = prod_s1 + POS_W'(samp_s1);
	assign diff2_n = {1'b0, pos_n} - (POS_W+1)'(SECOND_FIELD_START);

	logic [POS_W-1:0] pos_s2;
	logic [POS_W-1:0] d2_s2;
	logic             ge2_s2;
	side_t            side_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			pos_s2  <= pos_n;
			d2_s2   <= diff2_n[POS_W-1:0];
			ge2_s2  <= !diff2_n[POS_W];
			side_s2 <= side_s1;
		end
	end

	// stage 3: field sync pulse lanes for both fields
	pcl_pkg::fsync_t fs1_n, fs2_n;

	pcl_field_sync #(
		.W         (POS_W),
		.HALF_LINE (HALF_LINE)
	) u_field_one (
		.offset            (pos_s2),
		.started           (1'b1),
		.equalising_length (cfg.equalising_length),
		.broad_length      (cfg.broad_length),
		.flags             (fs1_n)
	);

	pcl_field_sync #(
		.W         (POS_W),
		.HALF_LINE (HALF_LINE)
	) u_field_two (
		.offset            (d2_s2),
		.started           (ge2_s2),
		.equalising_length (cfg.equalising_length),
		.broad_length      (cfg.broad_length),
		.flags             (fs2_n)
	);

	pcl_pkg::fsync_t fs1_s3, fs2_s3;
	side_t           side_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			fs1_s3  <= fs1_n;
			fs2_s3  <= fs2_n;
			side_s3 <= side_s2;
		end
	end

	// stage 4: merge levels, later rules override earlier ones
	logic [pcl_pkg::LEVEL_W-1:0] lvl_n;
	logic [pcl_pkg::COL_W-1:0]   col_n;
	logic [pcl_pkg::ROW_W-1:0]   row_n;

	always_comb begin
		lvl_n = side_s3.hsync ? pcl_pkg::LVL_SYNC : pcl_pkg::LVL_BLACK;
		if (fs1_s3.blank) begin
			lvl_n = pcl_pkg::LVL_BLACK;
		end
		if (fs1_s3.pulse) begin
			lvl_n = pcl_pkg::LVL_SYNC;
		end
		if (fs2_s3.blank) begin
			lvl_n = pcl_pkg::LVL_BLACK;
		end
		if (fs2_s3.pulse) begin
			lvl_n = pcl_pkg::LVL_SYNC;
		end
		if (side_s3.in_pic && side_s3.lit) begin
			lvl_n = pcl_pkg::LVL_WHITE;
		end
		// position past the end of the line is plain black
		if (!side_s3.s_ok) begin
			lvl_n = pcl_pkg::LVL_BLACK;
		end
		col_n = side_s3.in_pic ? side_s3.col : '0;
		row_n = side_s3.in_pic ? side_s3.row : '0;
	end

	logic [pcl_pkg::LEVEL_W-1:0] level_s4;
	logic                        in_pic_s4;
	logic [pcl_pkg::COL_W-1:0]   col_s4;
	logic [pcl_pkg::ROW_W-1:0]   row_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			level_s4  <= lvl_n;
			in_pic_s4 <= side_s3.in_pic;
			col_s4    <= col_n;
			row_s4    <= row_n;
		end
	end

	assign out_valid     = v_s4;
	assign level         = level_s4;
	assign in_picture    = in_pic_s4;
	assign source_column = col_s4;
	assign source_row    = row_s4;

endmodule

[sv/pcl_checker.sv]
`timescale 1ns / 1ps

module pcl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [pcl_pkg::LEVEL_W-1:0] level,
	input logic                        in_picture,
	input logic [pcl_pkg::COL_W-1:0]   source_column,
	input logic [pcl_pkg::ROW_W-1:0]   source_row
);

	// a stalled item stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output item dropped while stalled");

	// a stalled item keeps its level
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(level))
		else $error("output level changed while stalled");

	// white is only shown inside the picture window
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (level == pcl_pkg::LVL_WHITE) |-> in_picture)
		else $error("white level outside picture window");

	// coordinates are cleared outside the picture window
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_picture |-> (source_column == '0) && (source_row == '0))
		else $error("source coordinates set outside picture window");

endmodule

bind pal_composite_level_generator_core pcl_checker u_pcl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.level         (level),
	.in_picture    (in_picture),
	.source_column (source_column),
	.source_row    (source_row)
);
